// ----- rtl/nso_pkg.sv -----
// ----------------------------------------------------------------------------
// nso_pkg
// Types and constants shared by the note sequencer oscillator modules.
// ----------------------------------------------------------------------------
package nso_pkg;

	localparam logic OPCODE_TICK  = 1'b0;
	localparam logic OPCODE_WRITE = 1'b1;

	localparam logic [1:0] REG_REFERENCE_STEP = 2'd0;
	localparam logic [1:0] REG_VOLUME         = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam logic [31:0] RESET_REFERENCE_STEP = 32'd39370534;
	localparam logic [15:0] RESET_VOLUME         = 16'd16384;
	localparam logic [6:0]  RESET_PATTERN_LENGTH = 7'd1;

	localparam logic [31:0] Q30_ONE = 32'd1073741824;
	localparam logic [31:0] SIN_C1  = 32'd1686629713;
	localparam logic [31:0] SIN_C3  = 32'd693598669;
	localparam logic [31:0] SIN_C5  = 32'd85569306;
	localparam logic [31:0] SIN_C7  = 32'd5026995;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REREAD,
		ST_STEP_MUL,
		ST_STEP_ADD,
		ST_WAVE,
		ST_T2,
		ST_R5,
		ST_R3,
		ST_R1,
		ST_S,
		ST_CAP,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WRITE,
		OP_CHECK,
		OP_STEP_MUL,
		OP_STEP_ADD,
		OP_WAVE,
		OP_T2,
		OP_R5,
		OP_R3,
		OP_R1,
		OP_S,
		OP_CAP,
		OP_SCALE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic due;
		logic wave;
	} dp_status_t;

	// 2^(s/12) in unsigned q2.30
	function automatic logic [31:0] semitone_ratio(input logic [3:0] s);
		logic [31:0] r;
		case (s)
			4'd1:    r = 32'd1137589835;
			4'd2:    r = 32'd1205234447;
			4'd3:    r = 32'd1276901417;
			4'd4:    r = 32'd1352829926;
			4'd5:    r = 32'd1433273380;
			4'd6:    r = 32'd1518500250;
			4'd7:    r = 32'd1608794974;
			4'd8:    r = 32'd1704458901;
			4'd9:    r = 32'd1805811301;
			4'd10:   r = 32'd1913190429;
			4'd11:   r = 32'd2026954652;
			default: r = 32'd1073741824;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/note_sequencer_oscillator.sv -----
// ----------------------------------------------------------------------------
// note_sequencer_oscillator
// Step sequencer over a pattern of notes driving a phase accumulator
// oscillator with sine or square output, gain and saturation.
//
//   channel  signals                                  direction
//   in       in_valid/in_ready, opcode, entry_*        input words
//   out      out_valid/out_ready, left/right_sample,   result words
//            note_position
//   cfg      cfg_write, cfg_index, cfg_data            register writes
//
// a write word is taken in the idle state; a tick steps from accept to the next
// accept through the polynomial for sine and skips it for square, with one more
// step when the note advances, all set by the single 32x32 multiplier stepping
// through phase step, polynomial and gain
// reset clears pointer, sample count, phase and the registers; pattern
// memory holds no reset value
// a finished result waits in the output register; a tick whose result
// finds that register full holds in its last step until it drains
// ----------------------------------------------------------------------------
module note_sequencer_oscillator #(
	parameter int PATTERN_DEPTH   = 64,
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [5:0]                    entry_index,
	input  logic [6:0]                    entry_key,
	input  logic                          entry_wave,
	input  logic [15:0]                   entry_duration,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_sample,
	output logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic [5:0]                    note_position,
	input  logic                          cfg_write,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	import nso_pkg::*;

	dp_cmd_t                cmd;
	dp_status_t             status;
	logic [SAMPLE_BITS-1:0] sample;
	logic [5:0]             position;
	logic                   out_free;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [5:0]             position_q;

	assign out_free = !out_valid_q || out_ready;

	nso_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.out_free (out_free),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	nso_datapath #(
		.PATTERN_DEPTH   (PATTERN_DEPTH),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.entry_index    (entry_index),
		.entry_key      (entry_key),
		.entry_wave     (entry_wave),
		.entry_duration (entry_duration),
		.status         (status),
		.sample         (sample),
		.position       (position)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_q   <= sample;
			position_q <= position;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_sample   = $signed(sample_q);
	assign right_sample  = $signed(sample_q);
	assign note_position = position_q;

endmodule

// ----- rtl/nso_ctrl.sv -----
// ----------------------------------------------------------------------------
// nso_ctrl
// Sequencer for one input word: pattern write or the steps of one sample tick.
// ----------------------------------------------------------------------------
module nso_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                opcode,
	input  logic                out_free,
	input  nso_pkg::dp_status_t status,
	output logic                in_ready,
	output nso_pkg::dp_cmd_t    cmd
);
	import nso_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OPCODE_WRITE) begin
						cmd.op = OP_WRITE;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.op  = OP_CHECK;
				state_d = status.due ? ST_REREAD : ST_STEP_MUL;
			end
			ST_REREAD: begin
				state_d = ST_STEP_MUL;
			end
			ST_STEP_MUL: begin
				cmd.op  = OP_STEP_MUL;
				state_d = ST_STEP_ADD;
			end
			ST_STEP_ADD: begin
				cmd.op  = OP_STEP_ADD;
				state_d = ST_WAVE;
			end
			ST_WAVE: begin
				cmd.op  = OP_WAVE;
				state_d = status.wave ? ST_SCALE : ST_T2;
			end
			ST_T2: begin
				cmd.op  = OP_T2;
				state_d = ST_R5;
			end
			ST_R5: begin
				cmd.op  = OP_R5;
				state_d = ST_R3;
			end
			ST_R3: begin
				cmd.op  = OP_R3;
				state_d = ST_R1;
			end
			ST_R1: begin
				cmd.op  = OP_R1;
				state_d = ST_S;
			end
			ST_S: begin
				cmd.op  = OP_S;
				state_d = ST_CAP;
			end
			ST_CAP: begin
				cmd.op  = OP_CAP;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op  = OP_SCALE;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/nso_datapath.sv -----
// ----------------------------------------------------------------------------
// nso_datapath
// Pattern memory, note pointer, phase accumulator and a shared multiplier
// that works through phase step, sine polynomial and gain in turn.
// ----------------------------------------------------------------------------
module nso_datapath #(
	parameter int PATTERN_DEPTH   = 64,
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nso_pkg::dp_cmd_t         cmd,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic [5:0]               entry_index,
	input  logic [6:0]               entry_key,
	input  logic                     entry_wave,
	input  logic [15:0]              entry_duration,
	output nso_pkg::dp_status_t      status,
	output logic [SAMPLE_BITS-1:0]   sample,
	output logic [5:0]               position
);
	import nso_pkg::*;

	localparam int PW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam logic [10:0] DEPTH_EXT = 11'(PATTERN_DEPTH);
	localparam int QB = SINE_TABLE_BITS - 2;
	localparam logic [SAMPLE_BITS:0] HALF = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

	// configuration
	logic [31:0] reference_step_q;
	logic [15:0] volume_q;
	logic [6:0]  pattern_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_step_q <= RESET_REFERENCE_STEP;
			volume_q         <= RESET_VOLUME;
			pattern_length_q <= RESET_PATTERN_LENGTH;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_REFERENCE_STEP: reference_step_q <= cfg_data;
				REG_VOLUME:         volume_q         <= cfg_data[15:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[6:0];
				default:            ;
			endcase
		end
	end

	// pattern memory
	logic [23:0]   mem [PATTERN_DEPTH];
	logic [23:0]   rdata_q;
	logic [PW-1:0] pointer_q;
	logic [15:0]   index_ext;
	logic          mem_we;

	assign index_ext = 16'(entry_index);
	assign mem_we    = (cmd.op == OP_WRITE) && (index_ext < 16'(PATTERN_DEPTH));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[index_ext[PW-1:0]] <= {entry_duration, entry_wave, entry_key};
		end
		rdata_q <= mem[pointer_q];
	end

	// pointer advance
	logic [10:0]   len;
	logic [10:0]   length_ext;
	logic [10:0]   next_ext;
	logic [PW-1:0] next_ptr;
	logic [15:0]   elapsed_q;
	logic [15:0]   pos_ext;

	always_comb begin
		length_ext = 11'(pattern_length_q);
		if (length_ext == 11'd0) begin
			len = 11'd1;
		end else if (length_ext > DEPTH_EXT) begin
			len = DEPTH_EXT;
		end else begin
			len = length_ext;
		end
		next_ext = 11'(pointer_q) + 11'd1;
		next_ptr = (next_ext >= len) ? '0 : next_ext[PW-1:0];
	end

	assign status.due  = elapsed_q >= rdata_q[23:8];
	assign pos_ext     = 16'(pointer_q);
	assign position    = pos_ext[5:0];

	// phase step operands
	logic [63:0] prod_q;
	logic [7:0]  key_d;
	logic [15:0] key_recip;
	logic [3:0]  oct;
	logic [7:0]  semi;
	logic [3:0]  oct_q;
	logic        wave_q;
	logic [5:0]  shift_amt;
	logic [63:0] step_full;

	assign key_d     = 8'(rdata_q[6:0]) + 8'd3;
	assign key_recip = 16'(key_d) * 16'd171;
	assign oct       = key_recip[14:11];
	assign semi      = key_d - (8'({oct, 3'b000}) + 8'({oct, 2'b00}));
	assign shift_amt = 6'd36 - 6'(oct_q);
	assign step_full = prod_q >> shift_amt;
	assign status.wave = wave_q;

	// sine index
	logic [31:0]              phase_q;
	logic [SINE_TABLE_BITS-1:0] sidx;
	logic [QB:0]              p_mir;
	logic [31:0]              t_val;

	always_comb begin
		sidx = phase_q[31 -: SINE_TABLE_BITS];
		if (sidx[QB]) begin
			p_mir = {1'b1, {QB{1'b0}}} - {1'b0, sidx[QB-1:0]};
		end else begin
			p_mir = {1'b0, sidx[QB-1:0]};
		end
		t_val = 32'(p_mir) << (32 - SINE_TABLE_BITS);
	end

	// shared multiplier
	logic [31:0] prod_hi;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        mul_en;
	logic [31:0] t_q;
	logic [31:0] t2_q;
	logic [31:0] mag_q;
	logic        neg_q;

	assign prod_hi = prod_q[61:30];

	always_comb begin
		mul_a  = t_q;
		mul_b  = t_q;
		mul_en = 1'b1;
		unique case (cmd.op)
			OP_STEP_MUL: begin
				mul_a = reference_step_q;
				mul_b = semitone_ratio(semi[3:0]);
			end
			OP_T2: begin
				mul_a = t_q;
				mul_b = t_q;
			end
			OP_R5: begin
				mul_a = prod_hi;
				mul_b = SIN_C7;
			end
			OP_R3: begin
				mul_a = t2_q;
				mul_b = SIN_C5 - prod_hi;
			end
			OP_R1: begin
				mul_a = t2_q;
				mul_b = SIN_C3 - prod_hi;
			end
			OP_S: begin
				mul_a = t_q;
				mul_b = SIN_C1 - prod_hi;
			end
			OP_SCALE: begin
				mul_a = mag_q;
				mul_b = 32'(volume_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.op)
			OP_STEP_MUL: begin
				oct_q  <= oct;
				wave_q <= rdata_q[7];
			end
			OP_WAVE: begin
				t_q   <= t_val;
				neg_q <= phase_q[31];
				mag_q <= Q30_ONE;
			end
			OP_R5: begin
				t2_q <= prod_hi;
			end
			OP_CAP: begin
				mag_q <= (prod_hi > Q30_ONE) ? Q30_ONE : prod_hi;
			end
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q <= '0;
			elapsed_q <= '0;
			phase_q   <= '0;
		end else begin
			case (cmd.op)
				OP_CHECK: begin
					if (status.due) begin
						elapsed_q <= '0;
						pointer_q <= next_ptr;
					end
				end
				OP_STEP_ADD: begin
					phase_q <= phase_q + step_full[31:0];
					if (elapsed_q != 16'hFFFF) begin
						elapsed_q <= elapsed_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// gain and saturation
	logic [SAMPLE_BITS:0] v;
	logic [SAMPLE_BITS:0] v_sat;
	logic [SAMPLE_BITS:0] v_neg;

	always_comb begin
		v = prod_q[46 -: (SAMPLE_BITS + 1)];
		if (neg_q) begin
			v_sat = (v > HALF) ? HALF : v;
		end else begin
			v_sat = (v > HALF - 1'b1) ? HALF - 1'b1 : v;
		end
		v_neg  = '0 - v_sat;
		sample = neg_q ? v_neg[SAMPLE_BITS-1:0] : v_sat[SAMPLE_BITS-1:0];
	end

endmodule
